// ----- rtl/substring_match_counter_assert.svh -----
// Assertion macros for the substring match counter.
// Depends on nothing; included by the top level, which supplies aclk and aresetn.
`ifndef SUBSTRING_MATCH_COUNTER_ASSERT_SVH
`define SUBSTRING_MATCH_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SMC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define SMC_ASSERT(lbl, prop, msg)
`define SMC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// ----- rtl/smc_pkg.sv -----
// Shared types, constants and helper functions of the substring match counter.
// No dependencies.
`timescale 1ns / 1ps
package smc_pkg;
    localparam int MAX_PATTERN = 16;
    localparam int POS_BITS    = 32;
    localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
    localparam int TOP_BITS    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [7:0] WORD_EXTRA = 8'h5F;

    // Register indexes
    localparam logic [2:0] REG_PAT_LOW  = 3'd0;
    localparam logic [2:0] REG_PAT_HIGH = 3'd1;
    localparam logic [2:0] REG_PAT_LEN  = 3'd2;
    localparam logic [2:0] REG_IGN_CASE = 3'd3;
    localparam logic [2:0] REG_WHOLE_WD = 3'd4;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } smc_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] match_start;
        logic [31:0] match_end;
        logic [31:0] match_count;
        logic        end_of_run;
    } smc_out_t;

    // Per-stream search state, kept in the state RAM
    typedef struct packed {
        logic [MAX_PATTERN-1:0] alive;
        logic [MAX_PATTERN-1:0] left;
        logic                   prev_word;
        logic                   after_match;
        logic                   pend_valid;
        logic [POS_BITS-1:0]    pend_start;
        logic [POS_BITS-1:0]    pos;
        logic [31:0]            count;
    } smc_state_t;

    localparam smc_state_t STATE_RESET = '{
        alive: '0, left: '0, prev_word: 1'b0, after_match: 1'b1,
        pend_valid: 1'b0, pend_start: '0, pos: '0, count: '0};

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == WORD_EXTRA);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        return (ic && c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
    endfunction

    // Saturating position add
    function automatic logic [POS_BITS-1:0] pos_add(input logic [POS_BITS-1:0] a,
                                                     input logic [LEN_BITS-1:0] b);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + (POS_BITS+1)'(b);
        return s[POS_BITS] ? '1 : s[POS_BITS-1:0];
    endfunction

    function automatic logic [31:0] cnt_inc(input logic [31:0] c);
        return (c == '1) ? c : (c + 32'd1);
    endfunction
endpackage

// ----- rtl/substring_match_counter.sv -----
// Substring match counter top level: state RAM read-modify-write and result queue.
// Depends on smc_pkg, smc_ram and substring_match_counter_assert.svh.
// Result words of an accepted input word are written into the result queue, which drives m_*.
// Throughput: one input word per cycle, set by the read-modify-write of the
// state word (forwarded from the last write); s_ready drops when the 8-entry result queue
// has fewer than 3 free slots. Reset (aresetn low, synchronous) empties the queue,
// restores register defaults and marks the state word as reset state.
`timescale 1ns / 1ps
`include "substring_match_counter_assert.svh"
module substring_match_counter (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  smc_pkg::smc_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output smc_pkg::smc_out_t m_data,
    input  logic            cfg_wr_en,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_wdata
);
    import smc_pkg::*;

    localparam int SW = $bits(smc_state_t);
    localparam int QD = 8;

    // Configuration registers
    logic [63:0]         pat_low_reg, pat_high_reg;
    logic [4:0]          pat_len_reg;
    logic                ign_case_reg, whole_words_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            pat_len_reg     <= 5'd1;
            ign_case_reg    <= 1'b0;
            whole_words_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PAT_LOW:  pat_low_reg     <= cfg_wdata;
                REG_PAT_HIGH: pat_high_reg    <= cfg_wdata;
                REG_PAT_LEN:  pat_len_reg     <= cfg_wdata[4:0];
                REG_IGN_CASE: ign_case_reg    <= cfg_wdata[0];
                REG_WHOLE_WD: whole_words_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // State RAM with forwarding of the most recent write
    logic       s_fire;
    smc_state_t st_cur, st_next, fwd_reg;
    logic [SW-1:0] ram_rdata;
    logic       init_reg, wrote_last_reg;

    smc_ram #(.WIDTH(SW), .DEPTH(2)) u_state_ram (
        .aclk  (aclk),
        .we    (s_fire),
        .waddr (1'b0),
        .wdata (st_next),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg       <= 1'b0;
            wrote_last_reg <= 1'b0;
        end else begin
            init_reg       <= init_reg | s_fire;
            wrote_last_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_reg <= st_next;
        end
    end

    assign st_cur = !init_reg ? STATE_RESET :
                    (wrote_last_reg ? fwd_reg : smc_state_t'(ram_rdata));

    // Pattern bytes as an array
    logic [7:0] pat [MAX_PATTERN];
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < 8) begin
                pat[k] = pat_low_reg[8*(k%8) +: 8];
            end else if (k < 16) begin
                pat[k] = pat_high_reg[8*(k%8) +: 8];
            end else begin
                pat[k] = 8'h00;
            end
        end
    end

    // Per-byte search step
    smc_out_t   res [3];
    logic [1:0] res_n;

    always_comb begin
        logic [LEN_BITS-1:0]    len;
        logic [TOP_BITS-1:0]    top;
        logic [MAX_PATTERN-1:0] mask, eq, alive, left;
        logic [7:0]             fc;
        logic                   wd, am0, start_ok, acc, left_ok;
        logic [POS_BITS-1:0]    start;
        logic [31:0]            cnt;
        len   = (pat_len_reg > 5'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN)
                                                : LEN_BITS'(pat_len_reg);
        top   = TOP_BITS'(len - LEN_BITS'(1));
        fc    = fold(s_data.data_byte, ign_case_reg);
        wd    = is_word(s_data.data_byte);
        cnt   = st_cur.count;
        alive = st_cur.alive;
        left  = st_cur.left;
        am0   = st_cur.after_match;
        acc   = 1'b0;
        res_n = 2'd0;
        st_next = st_cur;
        st_next.pend_valid = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end

        // Decide a waiting whole-word match on its right neighbor
        if (st_cur.pend_valid && (!whole_words_reg || !wd)) begin
            cnt = cnt_inc(cnt);
            res[0] = '{kind: KIND_MATCH, match_start: 32'(st_cur.pend_start),
                       match_end: 32'(pos_add(st_cur.pend_start, len)),
                       match_count: cnt, end_of_run: 1'b0};
            res_n = 2'd1;
            alive = '0;
            left  = '0;
            am0   = 1'b1;
        end

        // Shift-and over all candidate starts
        for (int k = 0; k < MAX_PATTERN; k++) begin
            mask[k] = (LEN_BITS'(k) < len);
            eq[k]   = (fold(pat[k], ign_case_reg) == fc);
        end
        start_ok = am0 || !st_cur.prev_word;
        alive = ((alive << 1) | MAX_PATTERN'(1)) & eq & mask;
        left  = ((left << 1) | MAX_PATTERN'(start_ok)) & alive;
        start = (st_cur.pos >= POS_BITS'(top)) ? (st_cur.pos - POS_BITS'(top)) : '0;
        left_ok = left[top];
        if (len != '0 && alive[top]) begin
            alive[top] = 1'b0;
            left[top]  = 1'b0;
            if (!whole_words_reg || (left_ok && s_data.last_byte)) begin
                cnt = cnt_inc(cnt);
                res[res_n] = '{kind: KIND_MATCH, match_start: 32'(start),
                               match_end: 32'(pos_add(start, len)),
                               match_count: cnt, end_of_run: 1'b0};
                res_n = res_n + 2'd1;
                alive = '0;
                left  = '0;
                acc   = 1'b1;
            end else if (left_ok) begin
                st_next.pend_valid = 1'b1;
                st_next.pend_start = start;
            end
        end
        if (len == '0) begin
            alive = '0;
            left  = '0;
        end

        st_next.alive       = alive;
        st_next.left        = left;
        st_next.after_match = acc;
        st_next.prev_word   = wd;
        st_next.pos         = pos_add(st_cur.pos, LEN_BITS'(1));
        st_next.count       = cnt;

        // End of text: summary, then fresh stream state
        if (s_data.last_byte) begin
            res[res_n] = '{kind: KIND_SUMMARY, match_start: '0, match_end: '0,
                           match_count: cnt, end_of_run: 1'b0};
            res_n = res_n + 2'd1;
            st_next = STATE_RESET;
        end
        if (res_n != 2'd0) begin
            res[res_n - 2'd1].end_of_run = 1'b1;
        end
    end

    // Result queue
    smc_out_t   q_reg [QD];
    logic [2:0] wr_ptr_reg, rd_ptr_reg;
    logic [3:0] cnt_reg;
    logic       m_fire;

    assign s_ready = (cnt_reg <= 4'(QD - 3));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (cnt_reg != 4'd0);
    assign m_fire  = m_valid && m_ready;
    assign m_data  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < res_n) begin
                    q_reg[wr_ptr_reg + 3'(i)] <= res[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + (s_fire ? 3'(res_n) : 3'd0);
            rd_ptr_reg <= rd_ptr_reg + 3'(m_fire);
            cnt_reg    <= cnt_reg + (s_fire ? 4'(res_n) : 4'd0) - 4'(m_fire);
        end
    end

    // Checks
    `SMC_ASSERT(a_q_bound, cnt_reg <= 4'(QD), "result queue overflow")
    `SMC_ASSERT_NEXT(a_last_gives_sum, s_fire && s_data.last_byte, m_valid, "no summary")
    `SMC_ASSERT_NEXT(a_last_clears, s_fire && s_data.last_byte, st_cur.pos == '0, "not cleared")
endmodule

// ----- rtl/smc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module smc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
